// ----- src/tft_pkg.sv -----
// Package: types, codes and constants for the TCP flow tracking table.
package tft_pkg;

	localparam int FlowEntriesDefault = 64;

	localparam logic [3:0] IpVersion4     = 4'd4;
	localparam logic [3:0] MinIpHdrWords  = 4'd5;
	localparam int         FinBit         = 0;
	localparam int         SynBit         = 1;
	localparam int         AckBit         = 4;
	localparam logic [1:0] FinCountClose  = 2'd2;

	typedef enum logic [2:0] {
		VERDICT_MALFORMED = 3'd0,
		VERDICT_UNTRACKED = 3'd1,
		VERDICT_FULL      = 3'd2,
		VERDICT_CLOSED    = 3'd3,
		VERDICT_NOPAYLOAD = 3'd4,
		VERDICT_PAYLOAD   = 3'd5
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_LAST,
		ST_DECIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ports;
		logic [1:0]  fin;
		logic        vld;
	} entry_t;

endpackage

// ----- src/tcp_flow_tracking_table_core.sv -----
// Top level: TCP flow tracking table with entry memory and sequential scan.
//
// Channel   Dir  Width  Contents
// s_axis    in   152    parsed IPv4/TCP header, one per transaction
// m_axis    out  32     classification result, one per input transaction
//
// Each header is handled by a scan of one memory read per entry to probe both
// keys and find the lowest free slot, then decide, write back and present.
// After reset a clearing pass marks every entry free; s_axis_tready stays low
// meanwhile. One header is in work at a time; a result held on m_axis blocks
// the next header until taken.
module tcp_flow_tracking_table_core #(
	parameter int FLOW_ENTRIES = tft_pkg::FlowEntriesDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// ip_version[3:0], ip_header_words[7:4], tcp_header_words[11:8],
	// captured_length[27:12], ip_total_length[43:28], more_fragments[44],
	// source_address[76:45], destination_address[108:77], source_port[124:109],
	// destination_port[140:125], tcp_flag_bits[148:141], zero fill
	input  logic [151:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// verdict[2:0], reply_direction[3], flow_opened[4], payload_bytes[20:5],
	// header_bytes[27:21], zero fill
	output logic [31:0]  m_axis_tdata
);

	localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

	tft_pkg::state_t state_q, state_d;

	logic [148:0] in_q;
	logic [AW-1:0] addr_q;
	logic [AW:0]   clr_q;

	tft_pkg::entry_t mem [FLOW_ENTRIES];
	tft_pkg::entry_t rd_s1;
	logic [AW-1:0]   ra_s1;
	logic            rd_scan_q;

	logic          fwd_hit_q, rev_hit_q, free_hit_q;
	logic [AW-1:0] fwd_idx_q, rev_idx_q, free_idx_q;
	tft_pkg::entry_t fwd_e_q, rev_e_q;

	logic [31:0] out_q;

	logic [3:0]  ver, ihl, thl;
	logic [15:0] cap, tot, sport, dport;
	logic        mf;
	logic [31:0] src, dst;
	logic [7:0]  flg;
	logic [4:0]  hwords;
	logic [6:0]  hdr;
	logic        bad, syn_only;
	logic [31:0] fwd_ports, rev_ports;

	assign ver = in_q[3:0];
	assign ihl = in_q[7:4];
	assign thl = in_q[11:8];
	assign cap = in_q[27:12];
	assign tot = in_q[43:28];
	assign mf  = in_q[44];
	assign src = in_q[76:45];
	assign dst = in_q[108:77];
	assign sport = in_q[124:109];
	assign dport = in_q[140:125];
	assign flg = in_q[148:141];
	assign hwords = {1'b0, ihl} + {1'b0, thl};
	assign hdr = {hwords, 2'b00};
	assign bad = (ver != tft_pkg::IpVersion4) || (ihl < tft_pkg::MinIpHdrWords) ||
		(cap < tot) || mf || ({9'd0, hdr} > tot);
	assign syn_only = flg[tft_pkg::SynBit] && !flg[tft_pkg::AckBit];
	assign fwd_ports = {sport, dport};
	assign rev_ports = {dport, sport};

	logic last_addr;
	assign last_addr = (addr_q == AW'(FLOW_ENTRIES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			tft_pkg::ST_CLEAR: if (clr_q == (AW+1)'(FLOW_ENTRIES - 1)) state_d = tft_pkg::ST_IDLE;
			tft_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = tft_pkg::ST_SCAN;
			tft_pkg::ST_SCAN:  if (last_addr) state_d = tft_pkg::ST_LAST;
			tft_pkg::ST_LAST:  state_d = tft_pkg::ST_DECIDE;
			tft_pkg::ST_DECIDE: state_d = tft_pkg::ST_OUT;
			tft_pkg::ST_OUT:   if (m_axis_tready) state_d = tft_pkg::ST_IDLE;
			default:           state_d = tft_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == tft_pkg::ST_IDLE);
		m_axis_tvalid = (state_q == tft_pkg::ST_OUT);
	end
	assign m_axis_tdata = out_q;

	logic rd_fwd, rd_rev;
	assign rd_fwd = rd_s1.vld && rd_s1.src == src && rd_s1.dst == dst &&
		rd_s1.ports == fwd_ports;
	assign rd_rev = rd_s1.vld && rd_s1.src == dst && rd_s1.dst == src &&
		rd_s1.ports == rev_ports;

	// decision
	logic            hit, do_write, do_free;
	logic [AW-1:0]   widx;
	tft_pkg::entry_t wentry, cur;
	logic [2:0]      verd;
	logic            reply, opened;
	logic [15:0]     pay, diff;
	logic [1:0]      fin_n;

	always_comb begin
		hit = fwd_hit_q || rev_hit_q;
		reply = !fwd_hit_q && rev_hit_q;
		cur = fwd_hit_q ? fwd_e_q : rev_e_q;
		widx = fwd_hit_q ? fwd_idx_q : rev_idx_q;
		opened = 1'b0;
		do_write = 1'b0;
		do_free = 1'b0;
		pay = '0;
		diff = tot - {9'd0, hdr};
		verd = tft_pkg::VERDICT_MALFORMED;
		if (!hit && syn_only) begin
			cur = '{src: src, dst: dst, ports: fwd_ports, fin: 2'd0, vld: 1'b1};
			widx = free_idx_q;
		end
		fin_n = cur.fin + 2'd1;
		wentry = cur;
		if (bad) begin
			reply = 1'b0;
			verd = tft_pkg::VERDICT_MALFORMED;
		end else if (!hit && !syn_only) begin
			verd = tft_pkg::VERDICT_UNTRACKED;
		end else if (!hit && !free_hit_q) begin
			verd = tft_pkg::VERDICT_FULL;
		end else begin
			opened = !hit;
			do_write = 1'b1;
			verd = tft_pkg::VERDICT_NOPAYLOAD;
			if (flg[tft_pkg::FinBit]) begin
				wentry.fin = fin_n;
				if (fin_n == tft_pkg::FinCountClose) do_free = 1'b1;
			end
			wentry.vld = !do_free;
			if (do_free) verd = tft_pkg::VERDICT_CLOSED;
			else if (diff != 16'd0) begin
				verd = tft_pkg::VERDICT_PAYLOAD;
				pay = diff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tft_pkg::ST_IDLE) in_q <= s_axis_tdata[148:0];
		rd_s1 <= mem[addr_q];
		ra_s1 <= addr_q;
		if (state_q == tft_pkg::ST_CLEAR) mem[clr_q[AW-1:0]] <= '0;
		else if (state_q == tft_pkg::ST_DECIDE && do_write) mem[widx] <= wentry;
		if (state_q == tft_pkg::ST_DECIDE)
			out_q <= {4'd0, hdr, pay, opened, reply, verd};
		if (rd_scan_q && rd_fwd && !fwd_hit_q) begin
			fwd_e_q <= rd_s1;
			fwd_idx_q <= ra_s1;
		end
		if (rd_scan_q && rd_rev && !rev_hit_q) begin
			rev_e_q <= rd_s1;
			rev_idx_q <= ra_s1;
		end
		if (rd_scan_q && !rd_s1.vld && !free_hit_q) free_idx_q <= ra_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tft_pkg::ST_CLEAR;
			addr_q <= '0;
			clr_q <= '0;
			rd_scan_q <= 1'b0;
			fwd_hit_q <= 1'b0;
			rev_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_scan_q <= (state_q == tft_pkg::ST_SCAN);
			if (state_q == tft_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == tft_pkg::ST_SCAN) addr_q <= last_addr ? '0 : addr_q + 1'b1;
			if (state_q == tft_pkg::ST_IDLE) begin
				fwd_hit_q <= 1'b0;
				rev_hit_q <= 1'b0;
				free_hit_q <= 1'b0;
				addr_q <= '0;
			end else if (rd_scan_q) begin
				if (rd_fwd) fwd_hit_q <= 1'b1;
				if (rd_rev) rev_hit_q <= 1'b1;
				if (!rd_s1.vld) free_hit_q <= 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tft_pkg::ST_OUT && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[3])
		else $error("opened flow reported as reply");

endmodule

// ----- verif/tft_flow_checker.sv -----
// Checker: watches both streams of the TCP flow tracking table, predicts each result and compares.
module tft_flow_checker #(
	parameter int FLOW_ENTRIES = tft_pkg::FlowEntriesDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [151:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [31:0]  m_axis_tdata,
	output int           fail_count,
	output int           pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0]         hdr;
		logic [15:0]        payload;
		logic               opened;
		logic               reply;
		tft_pkg::verdict_t  verdict;
	} flow_result_t;

	logic        flow_live [FLOW_ENTRIES];
	logic [31:0] flow_src  [FLOW_ENTRIES];
	logic [31:0] flow_dst  [FLOW_ENTRIES];
	logic [31:0] flow_ports[FLOW_ENTRIES];
	logic [1:0]  flow_fins [FLOW_ENTRIES];
	flow_result_t result_queue[$];

	function automatic int lookup_flow(logic [31:0] a, logic [31:0] b, logic [31:0] p);
		for (int i = 0; i < FLOW_ENTRIES; i++)
			if (flow_live[i] && flow_src[i] == a && flow_dst[i] == b && flow_ports[i] == p)
				return i;
		return -1;
	endfunction

	function automatic flow_result_t classify_packet(logic [151:0] d);
		logic [3:0]  ver, ihl, thl;
		logic [15:0] cap, tot, sport, dport;
		logic        mf;
		logic [31:0] src, dst;
		logic [7:0]  fl;
		int          hdr, idx;
		flow_result_t r;
		ver = d[3:0]; ihl = d[7:4]; thl = d[11:8]; cap = d[27:12]; tot = d[43:28];
		mf = d[44]; src = d[76:45]; dst = d[108:77]; sport = d[124:109];
		dport = d[140:125]; fl = d[148:141];
		hdr = (ihl + thl) * 4;
		r = '0;
		r.hdr = hdr[6:0];
		if (ver != tft_pkg::IpVersion4 || ihl < tft_pkg::MinIpHdrWords || cap < tot || mf ||
				hdr > tot) begin
			r.verdict = tft_pkg::VERDICT_MALFORMED;
			return r;
		end
		idx = lookup_flow(src, dst, {sport, dport});
		if (idx < 0) begin
			idx = lookup_flow(dst, src, {dport, sport});
			if (idx >= 0)
				r.reply = 1'b1;
		end
		if (idx < 0 && fl[tft_pkg::SynBit] && !fl[tft_pkg::AckBit]) begin
			for (int i = 0; i < FLOW_ENTRIES; i++)
				if (!flow_live[i]) begin
					idx = i;
					break;
				end
			if (idx < 0) begin
				r.verdict = tft_pkg::VERDICT_FULL;
				return r;
			end
			flow_live[idx] = 1'b1;
			flow_src[idx] = src;
			flow_dst[idx] = dst;
			flow_ports[idx] = {sport, dport};
			flow_fins[idx] = 2'd0;
			r.opened = 1'b1;
		end else if (idx < 0) begin
			r.verdict = tft_pkg::VERDICT_UNTRACKED;
			return r;
		end
		r.verdict = tft_pkg::VERDICT_NOPAYLOAD;
		if (fl[tft_pkg::FinBit]) begin
			flow_fins[idx] = flow_fins[idx] + 2'd1;
			if (flow_fins[idx] == tft_pkg::FinCountClose) begin
				flow_live[idx] = 1'b0;
				r.verdict = tft_pkg::VERDICT_CLOSED;
				return r;
			end
		end
		if (tot != hdr) begin
			r.verdict = tft_pkg::VERDICT_PAYLOAD;
			r.payload = 16'(tot - hdr);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		flow_result_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
			pending_results <= 0;
			result_queue.delete();
			for (int i = 0; i < FLOW_ENTRIES; i++)
				flow_live[i] = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[27:0];
				if (result_queue.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = result_queue.pop_front();
					if (got.verdict !== want.verdict || got.reply !== want.reply ||
							got.opened !== want.opened || got.payload !== want.payload ||
							got.hdr !== want.hdr || m_axis_tdata[31:28] !== 4'd0) begin
						$display("%0t: mismatch, expected %h, actual %h", $time, want,
							m_axis_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				result_queue.push_back(classify_packet(s_axis_tdata));
			pending_results <= result_queue.size();
		end
	end
endmodule

// ----- verif/tb_tcp_flow_tracking_table_core.sv -----
// Testbench top: drives packet headers into the TCP flow tracking table and gives the verdict.
module tb_tcp_flow_tracking_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Entries = tft_pkg::FlowEntriesDefault;
	localparam int CycleLimit = 1500000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [151:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	int           fail_count;
	int           pending_results;
	int           cycle_count = 0;
	logic [31:0]  host_pool[8];
	logic [31:0]  port_pool[8];

	tcp_flow_tracking_table_core #(.FLOW_ENTRIES(Entries)) dut (.*);

	tft_flow_checker #(.FLOW_ENTRIES(Entries)) flow_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				m_axis_tready <= 1'b0;
			else if (!m_axis_tready && arst_n) begin
				repeat ($urandom_range(0, 19) * ($urandom_range(0, 3) != 0)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_header(input logic [31:0] ver, ihl, thl, cap, tot, mf, src, dst,
			sport, dport, fl);
		int idle;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'd0, fl[7:0], dport[15:0], sport[15:0], dst, src, mf[0],
			tot[15:0], cap[15:0], thl[3:0], ihl[3:0], ver[3:0]};
		do @(posedge clk); while (!s_axis_tready);
		idle = $urandom_range(0, 19) * ($urandom_range(0, 3) != 0);
		if (idle != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_results == 0);
	endtask

	task automatic send_flow_packet(input bit wellformed);
		logic [31:0] ihl, thl, tot, cap, fl;
		int          a, b;
		ihl = $urandom_range(5, 15);
		thl = $urandom_range(0, 15);
		tot = (ihl + thl) * 4 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 65535 - 120));
		cap = tot + $urandom_range(0, 65535 - tot);
		fl = $urandom_range(0, 255);
		if ($urandom_range(0, 2) == 0)
			fl = 32'h2 | (fl & 32'h1);
		a = $urandom_range(0, 7);
		b = $urandom_range(0, 7);
		if ($urandom_range(0, 1))
			send_header(4, ihl, thl, cap, tot, 0, host_pool[a], host_pool[b],
				port_pool[a], port_pool[b], fl);
		else
			send_header(4, ihl, thl, cap, tot, 0, host_pool[b], host_pool[a],
				port_pool[b], port_pool[a], fl);
		if (!wellformed)
			send_header($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			host_pool[i] = $urandom;
			port_pool[i] = $urandom_range(0, 65535);
		end
		host_pool[0] = '0; host_pool[1] = '1; port_pool[0] = '0; port_pool[1] = 32'h0000ffff;

		send_header(5, 5, 5, 100, 100, 0, 1, 2, 3, 4, 32'h02);
		send_header(4, 4, 5, 100, 100, 0, 1, 2, 3, 4, 32'h02);
		send_header(4, 5, 5, 99, 100, 0, 1, 2, 3, 4, 32'h02);
		send_header(4, 5, 5, 100, 100, 1, 1, 2, 3, 4, 32'h02);
		send_header(4, 15, 15, 100, 100, 0, 1, 2, 3, 4, 32'h02);
		send_header(4, 5, 5, 100, 100, 0, 1, 2, 3, 4, 32'h10);
		send_header(4, 5, 5, 65535, 65535, 0, '1, '1, '1, '1, 32'h02);
		send_header(4, 5, 0, 20, 20, 0, '1, '1, '1, '1, 32'h12);
		send_header(4, 15, 15, 120, 120, 0, '0, '0, '0, '0, 32'h03);
		send_header(4, 5, 5, 40, 40, 0, 32'h0a000001, 32'h0a000002, 1000, 80, 32'h02);
		send_header(4, 5, 5, 60, 60, 0, 32'h0a000002, 32'h0a000001, 80, 1000, 32'h12);
		send_header(4, 5, 5, 70, 60, 0, 32'h0a000001, 32'h0a000002, 1000, 80, 32'h11);
		send_header(4, 5, 5, 90, 90, 0, 32'h0a000002, 32'h0a000001, 80, 1000, 32'hed);
		send_header(4, 5, 5, 90, 90, 0, 32'h0a000002, 32'h0a000001, 80, 1000, 32'h10);
		for (int i = 0; i < Entries + 2; i++)
			send_header(4, 5, 5, 40, 40, 0, 32'hc0a80000 + i, 7, i, 443, 32'h02);
		drain();
		for (int i = 0; i < Entries; i++)
			send_header(4, 5, 5, 40, 40, 0, 7, 32'hc0a80000 + i, 443, i,
				i[0] ? 32'h11 : 32'h01);
		for (int i = 0; i < Entries; i++)
			send_header(4, 5, 5, 40, 40, 0, 32'hc0a80000 + i, 7, i, 443, 32'h01);

		for (int n = 0; n < 620; n++)
			send_flow_packet($urandom_range(0, 9) != 0);

		drain();
		repeat (4 * (Entries + 4)) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
